// ----- rtl/wsrm_pkg.sv -----
// Package for the wildcard star regex matcher.
// Holds the payload types, the cell control struct, character codes and register indexes.
// No dependencies.
package wsrm_pkg;

   localparam int PATTERN_MAX_DEF = 32;

   localparam int PAT_REG_COUNT = 4;
   localparam int PAT_REG_W     = 64;
   localparam int LEN_REG_W     = 6;
   localparam int CSR_DATA_W    = 64;
   localparam int CSR_ADDR_W    = 6;
   localparam int CSR_INDEX_W   = 3;

   localparam logic [7:0] STAR_BYTE = 8'h2A;
   localparam logic [7:0] DOT_BYTE  = 8'h2E;

   // Register indexes, taken from paddr[5:3]
   localparam logic [CSR_INDEX_W-1:0] CSR_PAT_0_7   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAT_8_15  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAT_16_23 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAT_24_31 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAT_LEN   = 3'd4;

   typedef struct packed {
      logic [7:0] subject_byte;
      logic       starts_string;
   } req_type;

   typedef struct packed {
      logic prefix_matches;
      logic empty_subject_matches;
   } rsp_type;

   // Per-cell pattern view, fixed between configuration writes
   typedef struct packed {
      logic [7:0] pat_char;
      logic [7:0] prev_char;
      logic       has_prev;
      logic       in_use;
   } cell_cfg_type;

endpackage

// ----- rtl/wsrm_cell.sv -----
// One match cell of the row: computes the new match bit for one pattern prefix.
// Depends on wsrm_pkg.
module wsrm_cell (
   input  wsrm_pkg::cell_cfg_type cfg,
   input  logic [7:0]             subject_byte,
   input  logic                   old_cur,
   input  logic                   old_prev,
   input  logic                   chain_in,
   input  logic                   empty_chain_in,
   output logic                   row_bit,
   output logic                   empty_bit
);
   import wsrm_pkg::*;

   logic prev_hit;

   assign prev_hit = (cfg.prev_char == subject_byte) || (cfg.prev_char == DOT_BYTE);

   always_comb begin
      row_bit   = 1'b0;
      empty_bit = 1'b0;
      if (cfg.in_use) begin
         if (cfg.pat_char == STAR_BYTE) begin
            // star: skip the starred pair, or repeat it once more
            if (cfg.has_prev) begin
               row_bit   = chain_in | (prev_hit & old_cur);
               empty_bit = empty_chain_in;
            end
         end else if ((cfg.pat_char == DOT_BYTE) || (cfg.pat_char == subject_byte)) begin
            row_bit = old_prev;
         end
      end
   end

endmodule

// ----- rtl/wsrm_row.sv -----
// Row of match cells with the stored match row and the empty-subject row.
// Depends on wsrm_pkg and wsrm_cell.
module wsrm_row #(
   parameter int PATTERN_MAX = wsrm_pkg::PATTERN_MAX_DEF
) (
   input  logic                                                 clock,
   input  logic                                                 reset,
   input  logic [wsrm_pkg::PAT_REG_COUNT*wsrm_pkg::PAT_REG_W-1:0] pat_flat,
   input  logic [wsrm_pkg::LEN_REG_W-1:0]                       pattern_length,
   input  logic                                                 advance,
   input  wsrm_pkg::req_type                                    req,
   output wsrm_pkg::rsp_type                                    rsp
);
   import wsrm_pkg::*;

   localparam int LEN_W = $clog2(PATTERN_MAX + 1);

   logic [PATTERN_MAX:0] match_row_ff;
   logic [PATTERN_MAX:0] match_row_in;
   logic [PATTERN_MAX:0] empty_row_ff;
   logic [PATTERN_MAX:0] empty_row_in;
   logic [PATTERN_MAX:0] old_row;
   logic [LEN_W-1:0]     len_used;

   assign len_used = (pattern_length > LEN_REG_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                                 : pattern_length[LEN_W-1:0];

   // restart from the empty-subject row on a new string
   assign old_row = req.starts_string ? empty_row_ff : match_row_ff;

   assign match_row_in[0] = 1'b0;
   assign empty_row_in[0] = 1'b1;

   for (genvar j = 1; j <= PATTERN_MAX; j++) begin : g_cell
      cell_cfg_type cfg;
      logic [7:0]   prev_char;
      logic         has_prev;
      logic         chain_in;
      logic         empty_chain_in;

      if (j >= 2) begin : g_prev
         assign prev_char      = pat_flat[8*(j-2) +: 8];
         assign has_prev       = 1'b1;
         assign chain_in       = match_row_in[j-2];
         assign empty_chain_in = empty_row_in[j-2];
      end else begin : g_first
         assign prev_char      = 8'h00;
         assign has_prev       = 1'b0;
         assign chain_in       = 1'b0;
         assign empty_chain_in = 1'b0;
      end

      assign cfg = '{pat_char:  pat_flat[8*(j-1) +: 8],
                     prev_char: prev_char,
                     has_prev:  has_prev,
                     in_use:    (len_used >= LEN_W'(j))};

      wsrm_cell u_cell (
         .cfg            (cfg),
         .subject_byte   (req.subject_byte),
         .old_cur        (old_row[j]),
         .old_prev       (old_row[j-1]),
         .chain_in       (chain_in),
         .empty_chain_in (empty_chain_in),
         .row_bit        (match_row_in[j]),
         .empty_bit      (empty_row_in[j])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_row_ff <= '0;
         // empty row of the cleared pattern: only the zero-length prefix matches
         empty_row_ff <= {{PATTERN_MAX{1'b0}}, 1'b1};
      end else begin
         empty_row_ff <= empty_row_in;
         if (advance) begin
            match_row_ff <= match_row_in;
         end
      end
   end

   assign rsp.prefix_matches        = match_row_in[len_used];
   assign rsp.empty_subject_matches = empty_row_ff[len_used];

endmodule

// ----- rtl/wildcard_star_regex_matcher.sv -----
// Top level of the wildcard star regex matcher: register port, request handshake, result skid.
// Depends on wsrm_pkg and wsrm_row.
//
//   port group | direction | carries
//   req_*      | in        | subject byte and start-of-string flag
//   rsp_*      | out       | whole-pattern match and empty-subject match
//   csr_*      | in/out    | pattern bytes and pattern length
//
// One request per cycle while req_stall is low; its result appears in the next cycle when the output is free.
// The match row is computed combinationally: the star cells ripple through the row of cells.
// After each register write req_stall is high for one cycle while the empty row refreshes.
// An output register plus a skid entry keep requests flowing; apart from register writes,
// req_stall rises only when both are full. Synchronous reset clears the match row,
// registers and both output slots.
module wildcard_star_regex_matcher #(
   parameter int PATTERN_MAX = wsrm_pkg::PATTERN_MAX_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  wsrm_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output wsrm_pkg::rsp_type                  rsp_data,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [wsrm_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [wsrm_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [wsrm_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);
   import wsrm_pkg::*;

   logic [PAT_REG_COUNT-1:0][PAT_REG_W-1:0] pattern_ff;
   logic [LEN_REG_W-1:0]                    length_ff;
   logic                                    cfg_wait_ff;
   logic                                    out_valid_ff;
   logic                                    out_valid_in;
   rsp_type                                 out_data_ff;
   rsp_type                                 out_data_in;
   logic                                    skid_valid_ff;
   logic                                    skid_valid_in;
   rsp_type                                 skid_data_ff;
   rsp_type                                 skid_data_in;
   rsp_type                                 new_rsp;
   logic [CSR_INDEX_W-1:0]                  csr_index;
   logic                                    csr_write;
   logic                                    req_take;
   logic                                    rsp_take;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:CSR_ADDR_W-CSR_INDEX_W];
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff  <= '0;
         length_ff   <= '0;
         cfg_wait_ff <= 1'b0;
      end else begin
         cfg_wait_ff <= csr_write;
         if (csr_write) begin
            case (csr_index)
               CSR_PAT_0_7:   pattern_ff[0] <= csr_pwdata;
               CSR_PAT_8_15:  pattern_ff[1] <= csr_pwdata;
               CSR_PAT_16_23: pattern_ff[2] <= csr_pwdata;
               CSR_PAT_24_31: pattern_ff[3] <= csr_pwdata;
               CSR_PAT_LEN:   length_ff     <= csr_pwdata[LEN_REG_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      case (csr_index)
         CSR_PAT_0_7:   csr_prdata = pattern_ff[0];
         CSR_PAT_8_15:  csr_prdata = pattern_ff[1];
         CSR_PAT_16_23: csr_prdata = pattern_ff[2];
         CSR_PAT_24_31: csr_prdata = pattern_ff[3];
         CSR_PAT_LEN:   csr_prdata = CSR_DATA_W'(length_ff);
         default:       csr_prdata = '0;
      endcase
   end

   assign req_stall = skid_valid_ff | cfg_wait_ff;
   assign req_take  = req_valid & ~req_stall;
   assign rsp_take  = out_valid_ff & ~rsp_stall;

   wsrm_row #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_row (
      .clock          (clock),
      .reset          (reset),
      .pat_flat       (pattern_ff),
      .pattern_length (length_ff),
      .advance        (req_take),
      .req            (req_data),
      .rsp            (new_rsp)
   );

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || rsp_take) begin
         // refill the output slot, oldest request first
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = req_take;
            out_data_in  = new_rsp;
         end
      end else if (req_take) begin
         skid_valid_in = 1'b1;
         skid_data_in  = new_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// ----- rtl/wsrm_checker.sv -----
// Port-level checks for the wildcard star regex matcher, bound to the top level.
// Depends on wsrm_pkg and wildcard_star_regex_matcher.
module wsrm_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input wsrm_pkg::rsp_type               rsp_data,
   input logic                            csr_psel,
   input logic                            csr_penable,
   input logic                            csr_pwrite,
   input logic                            csr_pready
);
   import wsrm_pkg::*;

   logic req_take;
   logic csr_write;

   assign req_take  = req_valid & ~req_stall;
   assign csr_write = csr_psel & csr_penable & csr_pwrite & csr_pready;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("rsp_data changed while stalled");

   a_cfg_stall: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> req_stall)
      else $error("request taken right after a register write");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_take && !rsp_valid |=> rsp_valid)
      else $error("result missing one cycle after request into empty output");

   a_skid_full: assert property (@(posedge clock) disable iff (reset)
      req_take && rsp_valid && rsp_stall |=> req_stall)
      else $error("request path open with output and skid both full");

endmodule

bind wildcard_star_regex_matcher wsrm_checker u_wsrm_checker (.*);
